// ----- design/tea_pkg.sv -----
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  // Key register indexes on the configuration port
  typedef enum logic [1:0] {
    KEY_W0 = 2'd0,
    KEY_W1 = 2'd1,
    KEY_W2 = 2'd2,
    KEY_W3 = 2'd3
  } key_idx_e;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // One block in flight: direction plus both halves
  typedef struct packed {
    logic        func;
    logic [31:0] hi;
    logic [31:0] lo;
  } item_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                          input logic [31:0] sum,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ----- design/tea_if.sv -----
// ----------------------------------------------------------------------------
// tea_if
// Valid/ready channels carrying cipher requests and cipher results.
// ----------------------------------------------------------------------------
interface tea_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] block_high;
  logic [31:0] block_low;

  modport source (output valid, output func, output block_high, output block_low,
                  input ready);
  modport sink   (input valid, input func, input block_high, input block_low,
                  output ready);
endinterface

interface tea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_high;
  logic [31:0] out_low;

  modport source (output valid, output out_high, output out_low, input ready);
  modport sink   (input valid, input out_high, input out_low, output ready);
endinterface

// ----- design/tea_stage.sv -----
// ----------------------------------------------------------------------------
// tea_stage
// One registered half round: updates one block half from the other.
// ----------------------------------------------------------------------------
module tea_stage #(
  parameter logic [31:0] SumEnc = 32'h0,
  parameter logic [31:0] SumDec = 32'h0,
  parameter bit          Odd    = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tea_pkg::item_t item_i,
  input  tea_pkg::key_t  key_i,
  output logic           valid_o,
  output tea_pkg::item_t item_o
);

  logic           valid_q;
  tea_pkg::item_t item_d, item_q;
  logic           upd_high;
  logic [31:0]    src, tgt, sum, ka, kb, mix, res;

  // Enciphering updates high then low; deciphering low then high
  always_comb begin
    upd_high = item_i.func ? Odd : !Odd;
    src      = upd_high ? item_i.lo : item_i.hi;
    tgt      = upd_high ? item_i.hi : item_i.lo;
    ka       = upd_high ? key_i.k0 : key_i.k2;
    kb       = upd_high ? key_i.k1 : key_i.k3;
    sum      = item_i.func ? SumDec : SumEnc;
    mix      = tea_pkg::tea_mix(src, sum, ka, kb);
    res      = item_i.func ? (tgt - mix) : (tgt + mix);
    item_d   = item_i;
    if (upd_high) begin
      item_d.hi = res;
    end else begin
      item_d.lo = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/tea_block_cipher_16_round.sv -----
// ----------------------------------------------------------------------------
// tea_block_cipher_16_round
// Pipelined TEA block cipher, one half round per stage, with an output skid.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   func, block_high, block_low
// rsp      out  valid/ready   out_high, out_low
// cfg      in   cfg_we_i      cfg_idx_i selects key word, cfg_data_i
//
// Throughput is one block per cycle while the skid entry is empty; a result
// passes through the chain of half-round stages and then the output register.
// Reset clears all valid bits and the four key words.
// The whole pipeline advances together while the skid entry is empty; a
// stalled result parks in the skid, and req.ready drops only while it is full.
// ----------------------------------------------------------------------------
module tea_block_cipher_16_round #(
  parameter int ROUND_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tea_req_if.sink     req,
  tea_rsp_if.source   rsp,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int Stages = 2 * ROUND_COUNT;

  tea_pkg::key_t  key_d, key_q;
  logic           en;
  logic [Stages:0] pipe_valid;
  tea_pkg::item_t  pipe_item [Stages+1];

  logic           out_valid_d, out_valid_q;
  logic           skid_valid_d, skid_valid_q;
  tea_pkg::item_t out_item_d, out_item_q;
  tea_pkg::item_t skid_item_d, skid_item_q;

  // Key registers
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (tea_pkg::key_idx_e'(cfg_idx_i))
        tea_pkg::KEY_W0: key_d.k0 = cfg_data_i;
        tea_pkg::KEY_W1: key_d.k1 = cfg_data_i;
        tea_pkg::KEY_W2: key_d.k2 = cfg_data_i;
        tea_pkg::KEY_W3: key_d.k3 = cfg_data_i;
        default:         key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Pipeline
  assign en        = !skid_valid_q;
  assign req.ready = en;

  assign pipe_valid[0]     = req.valid;
  assign pipe_item[0].func = req.func;
  assign pipe_item[0].hi   = req.block_high;
  assign pipe_item[0].lo   = req.block_low;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int          Round = s / 2;
    localparam logic [63:0] SumE  = 64'(tea_pkg::TEA_DELTA) * 64'(Round + 1);
    localparam logic [63:0] SumD  = 64'(tea_pkg::TEA_DELTA) * 64'(ROUND_COUNT - Round);

    tea_stage #(
      .SumEnc (SumE[31:0]),
      .SumDec (SumD[31:0]),
      .Odd    (1'((s % 2) == 1))
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[s]),
      .item_i  (pipe_item[s]),
      .key_i   (key_q),
      .valid_o (pipe_valid[s+1]),
      .item_o  (pipe_item[s+1])
    );
  end

  // Output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    skid_valid_d = skid_valid_q;
    skid_item_d  = skid_item_q;
    if (!out_valid_q || rsp.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_item_d   = skid_item_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = pipe_valid[Stages];
        out_item_d  = pipe_item[Stages];
      end
    end else if (pipe_valid[Stages] && en) begin
      // park the item leaving the last stage
      skid_valid_d = 1'b1;
      skid_item_d  = pipe_item[Stages];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.out_high = out_item_q.hi;
  assign rsp.out_low  = out_item_q.lo;

endmodule

// ----- design/tea_chk.sv -----
// ----------------------------------------------------------------------------
// tea_chk
// Port-level checks of the TEA pipeline: stalls, occupancy and back pressure.
// ----------------------------------------------------------------------------
module tea_chk #(
  parameter int ROUND_COUNT = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_high_i,
  input logic [31:0] out_low_i
);

  localparam int MaxOut = 2 * ROUND_COUNT + 2;
  localparam int CntW   = $clog2(MaxOut + 2);

  logic            in_acc, out_acc;
  logic [CntW-1:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track items accepted but not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_high_i) && $stable(out_low_i))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without an accepted item");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxOut))
    else $error("more items in flight than the pipeline holds");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled while the output is empty");

endmodule

bind tea_block_cipher_16_round tea_chk #(
  .ROUND_COUNT (ROUND_COUNT)
) u_tea_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req.valid),
  .in_ready_i  (req.ready),
  .out_valid_i (rsp.valid),
  .out_ready_i (rsp.ready),
  .out_high_i  (rsp.out_high),
  .out_low_i   (rsp.out_low)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the pipelined TEA cipher. A local model of the 16-round
// encipher/decipher predicts every block accepted on the request channel.
// Each response is checked in order against those predictions. Key words are
// rewritten between phases while the pipe is empty, and both channels stall
// at random. One phase holds the response side off until the input backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int ROUNDS          = 16;
  localparam int PIPE_LATENCY    = 2 * ROUNDS + 1;
  localparam int IDLE_PERCENT    = 33;
  localparam int RSP_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct {
    logic [31:0] hi;
    logic [31:0] lo;
  } cipher_out_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  tea_req_if req_ch ();
  tea_rsp_if rsp_ch ();

  tea_pkg::key_t cur_key;
  cipher_out_t   expected_blocks[$];
  int            mismatches;
  int            stall_cycles;
  bit            no_idle;
  int            hold_req;
  int            hold_seen;
  int            hold_left;

  tea_block_cipher_16_round #(
    .ROUND_COUNT(ROUNDS)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] half_round(input logic [31:0] v, input logic [31:0] s,
                                             input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  function automatic cipher_out_t tea_predict(input logic func, input logic [31:0] hi,
                                              input logic [31:0] lo,
                                              input tea_pkg::key_t k);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    cipher_out_t r;
    int          i;
    y = hi;
    z = lo;
    if (func == OP_ENCRYPT) begin
      s = '0;
      for (i = 0; i < ROUNDS; i++) begin
        s = s + tea_pkg::TEA_DELTA;
        y = y + half_round(z, s, k.k0, k.k1);
        z = z + half_round(y, s, k.k2, k.k3);
      end
    end else begin
      s = tea_pkg::TEA_DELTA * 32'(ROUNDS);
      for (i = 0; i < ROUNDS; i++) begin
        z = z - half_round(y, s, k.k2, k.k3);
        y = y - half_round(z, s, k.k0, k.k1);
        s = s - tea_pkg::TEA_DELTA;
      end
    end
    r.hi = y;
    r.lo = z;
    return r;
  endfunction

  // Response side: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = RSP_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    cipher_out_t exp_blk;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_blocks.push_back(tea_predict(req_ch.func, req_ch.block_high,
                                              req_ch.block_low, cur_key));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result %h_%h", rsp_ch.out_high, rsp_ch.out_low);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (rsp_ch.out_high !== exp_blk.hi || rsp_ch.out_low !== exp_blk.lo) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected %h_%h got %h_%h", exp_blk.hi, exp_blk.lo,
                       rsp_ch.out_high, rsp_ch.out_low);
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one item from the falling edge on, hold it until accepted
  task automatic send_block(input logic func, input logic [31:0] hi, input logic [31:0] lo);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.func       = func;
    req_ch.block_high = hi;
    req_ch.block_low  = lo;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drop_valid();
    wait_drained();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic program_keys(input tea_pkg::key_t k);
    wait_idle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = tea_pkg::KEY_W0;
    cfg_data = k.k0;
    @(negedge clk);
    cfg_idx  = tea_pkg::KEY_W1;
    cfg_data = k.k1;
    @(negedge clk);
    cfg_idx  = tea_pkg::KEY_W2;
    cfg_data = k.k2;
    @(negedge clk);
    cfg_idx  = tea_pkg::KEY_W3;
    cfg_data = k.k3;
    @(negedge clk);
    cfg_we   = 1'b0;
    cur_key  = k;
  endtask

  function automatic tea_pkg::key_t random_key();
    tea_pkg::key_t k;
    k.k0 = $urandom;
    k.k1 = $urandom;
    k.k2 = $urandom;
    k.k3 = $urandom;
    return k;
  endfunction

  // Send a block, then decipher-or-encipher its predicted output back
  task automatic send_round_trip(input logic func, input logic [31:0] hi,
                                 input logic [31:0] lo);
    cipher_out_t fwd;
    fwd = tea_predict(func, hi, lo, cur_key);
    send_block(func, hi, lo);
    send_block(~func, fwd.hi, fwd.lo);
  endtask

  task automatic test_reset_key();
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
  endtask

  task automatic test_key_extremes();
    program_keys('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
    send_block(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
    send_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    program_keys('{32'h0000_0001, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000});
    send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    send_block(OP_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_round_trip();
    int i;
    program_keys(random_key());
    for (i = 0; i < 4; i++)
      send_round_trip(1'($urandom), $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    int i;
    no_idle = 1'b1;
    hold_req++;
    for (i = 0; i < 60; i++)
      send_block(1'($urandom), $urandom, $urandom);
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 20; i++)
      send_block(1'($urandom), $urandom, $urandom);
    drop_valid();
    wait_drained();
    for (i = 0; i < 20; i++)
      send_block(1'($urandom), $urandom, $urandom);
  endtask

  task automatic test_random_traffic();
    int            phase;
    int            i;
    tea_pkg::key_t k;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        2: k = '{32'h0, 32'h0, 32'h0, 32'h0};
        4: k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        default: k = random_key();
      endcase
      program_keys(k);
      // one whole phase without idling on either side
      no_idle = (phase == 1);
      i = 0;
      while (i < 130) begin
        if ($urandom_range(0, 3) == 0) begin
          send_round_trip(1'($urandom), $urandom, $urandom);
          i += 2;
        end else begin
          send_block(1'($urandom), $urandom, $urandom);
          i++;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = tea_pkg::KEY_W0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = OP_ENCRYPT;
    req_ch.block_high = '0;
    req_ch.block_low  = '0;
    rsp_ch.ready      = 1'b0;
    cur_key           = '{32'h0, 32'h0, 32'h0, 32'h0};
    mismatches        = 0;
    stall_cycles      = 0;
    no_idle           = 1'b0;
    hold_req          = 0;
    hold_seen         = 0;
    hold_left         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_key();
    test_key_extremes();
    test_round_trip();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    drop_valid();
    wait_drained();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
